FILE: rtl/klx_pkg.sv
package klx_pkg;

   // token kinds
   localparam logic [4:0] KIND_END    = 5'd0;
   localparam logic [4:0] KIND_NUM    = 5'd1;
   localparam logic [4:0] KIND_VAR    = 5'd2;
   localparam logic [4:0] KIND_PLUS   = 5'd3;
   localparam logic [4:0] KIND_MINUS  = 5'd4;
   localparam logic [4:0] KIND_STAR   = 5'd5;
   localparam logic [4:0] KIND_SLASH  = 5'd6;
   localparam logic [4:0] KIND_TRUE   = 5'd7;
   localparam logic [4:0] KIND_FALSE  = 5'd8;
   localparam logic [4:0] KIND_EQ     = 5'd9;
   localparam logic [4:0] KIND_LEQ    = 5'd10;
   localparam logic [4:0] KIND_NOT    = 5'd11;
   localparam logic [4:0] KIND_AND    = 5'd12;
   localparam logic [4:0] KIND_ASSIGN = 5'd13;
   localparam logic [4:0] KIND_SKIP   = 5'd14;
   localparam logic [4:0] KIND_SEMI   = 5'd15;
   localparam logic [4:0] KIND_IF     = 5'd16;
   localparam logic [4:0] KIND_THEN   = 5'd17;
   localparam logic [4:0] KIND_ELSE   = 5'd18;
   localparam logic [4:0] KIND_FI     = 5'd19;
   localparam logic [4:0] KIND_WHILE  = 5'd20;
   localparam logic [4:0] KIND_DO     = 5'd21;
   localparam logic [4:0] KIND_DONE   = 5'd22;
   localparam logic [4:0] KIND_ERR    = 5'd23;

   localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;
   localparam logic [15:0] LEN_MAX = 16'hFFFF;
   localparam logic [15:0] PREFIX_BYTES = 16'd5;

   localparam logic [7:0] CHAR_LT    = 8'h3C;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_EQ    = 8'h3D;

   // keyword words, right-aligned in the 5-byte prefix
   localparam int KW_COUNT = 10;
   localparam logic [39:0] KW_TEXT [KW_COUNT] = '{
      {8'h00, "true"}, "false", {8'h00, "skip"}, {24'h0, "if"}, {8'h00, "then"},
      {8'h00, "else"}, {24'h0, "fi"}, "while", {24'h0, "do"}, {8'h00, "done"}
   };
   localparam logic [15:0] KW_LEN [KW_COUNT] = '{
      16'd4, 16'd5, 16'd4, 16'd2, 16'd4, 16'd4, 16'd2, 16'd5, 16'd2, 16'd4
   };
   localparam logic [4:0] KW_KIND [KW_COUNT] = '{
      KIND_TRUE, KIND_FALSE, KIND_SKIP, KIND_IF, KIND_THEN,
      KIND_ELSE, KIND_FI, KIND_WHILE, KIND_DO, KIND_DONE
   };

   typedef enum logic [4:0] {
      MODE_IDLE  = 5'b00001,
      MODE_NUM   = 5'b00010,
      MODE_WORD  = 5'b00100,
      MODE_LT    = 5'b01000,
      MODE_COLON = 5'b10000
   } scan_mode_type;

   typedef struct packed {
      logic [4:0]  kind;
      logic [30:0] value;
      logic [15:0] start;
      logic [15:0] length;
   } lex_token_type;

   // tokens caused by one input byte; first is always present
   typedef struct packed {
      lex_token_type first;
      lex_token_type second;
      logic          has_second;
   } token_pair_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic is_digit(logic [7:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return c inside {8'h20, [8'h09:8'h0D]};
   endfunction

   // single-byte operators; anything else is an error
   function automatic logic [4:0] single_op(logic [7:0] c);
      logic [4:0] k;
      case (c)
         8'h2B: k = KIND_PLUS;
         8'h2D: k = KIND_MINUS;
         8'h2A: k = KIND_STAR;
         8'h2F: k = KIND_SLASH;
         8'h3D: k = KIND_EQ;
         8'h21: k = KIND_NOT;
         8'h26: k = KIND_AND;
         8'h3B: k = KIND_SEMI;
         default: k = KIND_ERR;
      endcase
      return k;
   endfunction

   // parallel keyword compare; words longer than five never match
   function automatic logic [4:0] word_kind(logic [39:0] prefix, logic [15:0] len);
      logic [4:0] k;
      k = KIND_VAR;
      for (int i = 0; i < KW_COUNT; i++) begin
         if (len == KW_LEN[i] && prefix == KW_TEXT[i]) begin
            k = KW_KIND[i];
         end
      end
      return k;
   endfunction

endpackage

FILE: rtl/klx_front.sv
module klx_front import klx_pkg::*; #(
   parameter int POSITION_BITS = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  logic [7:0]     in_ch,
   input  logic           in_end,
   input  queue_status_type q_status,
   output logic           push,
   output token_pair_type push_data
);

   scan_mode_type mode_ff, mode_in;
   logic [30:0] accum_ff, accum_in;
   logic [39:0] prefix_ff, prefix_in;
   logic [15:0] wlen_ff, wlen_in;
   logic [POSITION_BITS-1:0] start_ff, start_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;

   logic accept, at_end, cont;
   logic pend_v, tail_v;
   lex_token_type pend, tail;
   logic [POSITION_BITS-1:0] pos_inc;
   logic [POSITION_BITS+15:0] start_ext, pos_ext;
   logic [34:0] acc_wide;
   logic [15:0] wlen_sat;

   assign in_ready = !q_status.full;
   assign accept   = in_valid && in_ready;
   assign at_end   = in_end || (in_ch == 8'h00);
   assign pos_inc  = pos_ff + 1'b1;
   // offsets report their low 16 bits, zero-filled for narrow counters
   assign start_ext = {16'h0000, start_ff};
   assign pos_ext   = {16'h0000, pos_ff};
   assign acc_wide  = {4'b0000, accum_ff} * 35'd10 + {31'h0, in_ch[3:0]};
   assign wlen_sat  = (wlen_ff < LEN_MAX) ? wlen_ff + 16'd1 : wlen_ff;

   always_comb begin
      mode_in   = mode_ff;
      accum_in  = accum_ff;
      prefix_in = prefix_ff;
      wlen_in   = wlen_ff;
      start_in  = start_ff;
      pos_in    = pos_ff;
      cont      = 1'b1;
      pend_v    = 1'b0;
      tail_v    = 1'b0;
      pend      = '0;
      tail      = '0;

      // close or extend the pending token
      case (mode_ff)
         MODE_NUM: begin
            if (!at_end && is_digit(in_ch)) begin
               accum_in = (acc_wide > {4'b0000, NUM_MAX}) ? NUM_MAX : acc_wide[30:0];
               wlen_in  = wlen_sat;
               pos_in   = pos_inc;
               cont     = 1'b0;
            end else begin
               pend_v  = 1'b1;
               pend    = '{KIND_NUM, accum_ff, start_ext[15:0], wlen_ff};
               mode_in = MODE_IDLE;
            end
         end
         MODE_WORD: begin
            if (!at_end && (is_alpha(in_ch) || is_digit(in_ch))) begin
               if (wlen_ff < PREFIX_BYTES) begin
                  prefix_in = {prefix_ff[31:0], in_ch};
               end
               wlen_in = wlen_sat;
               pos_in  = pos_inc;
               cont    = 1'b0;
            end else begin
               pend_v  = 1'b1;
               pend    = '{word_kind(prefix_ff, wlen_ff), 31'h0, start_ext[15:0], wlen_ff};
               mode_in = MODE_IDLE;
            end
         end
         MODE_LT, MODE_COLON: begin
            if (!at_end && in_ch == CHAR_EQ) begin
               tail_v  = 1'b1;
               tail    = '{(mode_ff == MODE_LT) ? KIND_LEQ : KIND_ASSIGN, 31'h0,
                           start_ext[15:0], 16'd2};
               mode_in = MODE_IDLE;
               pos_in  = pos_inc;
               cont    = 1'b0;
            end else begin
               // lone '<' or ':'
               pend_v  = 1'b1;
               pend    = '{KIND_ERR, 31'h0, start_ext[15:0], 16'd1};
               mode_in = MODE_IDLE;
            end
         end
         default: begin
            mode_in = MODE_IDLE;
         end
      endcase

      // this byte begins something new
      if (cont) begin
         if (at_end) begin
            tail_v    = 1'b1;
            tail      = '{KIND_END, 31'h0, pos_ext[15:0], 16'd0};
            mode_in   = MODE_IDLE;
            accum_in  = '0;
            prefix_in = '0;
            wlen_in   = '0;
            start_in  = '0;
            pos_in    = '0;
         end else begin
            start_in = pos_ff;
            pos_in   = pos_inc;
            if (is_digit(in_ch)) begin
               mode_in  = MODE_NUM;
               accum_in = {27'h0, in_ch[3:0]};
               wlen_in  = 16'd1;
            end else if (is_alpha(in_ch)) begin
               mode_in   = MODE_WORD;
               prefix_in = {32'h0, in_ch};
               wlen_in   = 16'd1;
            end else if (in_ch == CHAR_LT) begin
               mode_in = MODE_LT;
            end else if (in_ch == CHAR_COLON) begin
               mode_in = MODE_COLON;
            end else if (!is_space(in_ch)) begin
               tail_v = 1'b1;
               tail   = '{single_op(in_ch), 31'h0, pos_ext[15:0], 16'd1};
            end
         end
      end
   end

   assign push                 = accept && (pend_v || tail_v);
   assign push_data.first      = pend_v ? pend : tail;
   assign push_data.second     = tail;
   assign push_data.has_second = pend_v && tail_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         accum_ff  <= '0;
         prefix_ff <= '0;
         wlen_ff   <= '0;
         start_ff  <= '0;
         pos_ff    <= '0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         accum_ff  <= accum_in;
         prefix_ff <= prefix_in;
         wlen_ff   <= wlen_in;
         start_ff  <= start_in;
         pos_ff    <= pos_in;
      end
   end

endmodule

FILE: rtl/klx_queue.sv
module klx_queue import klx_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  token_pair_type   push_data,
   input  logic             pop,
   output token_pair_type   head,
   output queue_status_type status
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   token_pair_type entry_ff [DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] count_ff, count_in;

   assign wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
   assign rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign head         = entry_ff[rd_ff];
   assign status.full  = (count_ff == CW'(DEPTH));
   assign status.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_in;
         end
         if (pop) begin
            rd_ff <= rd_in;
         end
         count_ff <= count_in;
      end
   end

endmodule

FILE: rtl/klx_back.sv
module klx_back import klx_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  token_pair_type   head,
   output logic             pop,
   output logic             out_valid,
   input  logic             out_ready,
   output lex_token_type    out_token,
   output logic             out_last
);

   logic          valid_ff, valid_in;
   logic          phase_ff, phase_in;
   lex_token_type tok_ff, tok_in;
   logic          last_ff, last_in;
   logic          load;

   // output register refills whenever it is empty or being drained
   assign load = !q_status.empty && (!valid_ff || out_ready);

   always_comb begin
      tok_in   = phase_ff ? head.second : head.first;
      last_in  = phase_ff || !head.has_second;
      pop      = load && (phase_ff || !head.has_second);
      phase_in = load ? (!phase_ff && head.has_second) : phase_ff;
      valid_in = load ? 1'b1 : (valid_ff && !out_ready);
   end

   assign out_valid = valid_ff;
   assign out_token = tok_ff;
   assign out_last  = last_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         tok_ff  <= tok_in;
         last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

endmodule

FILE: rtl/keyword_token_lexer_top.sv
// Streaming lexer for a small while language. One source byte enters per req beat
// (tdata = the byte, tlast = end of text; byte 0 also ends the text) and tokens leave
// one per rsp beat, with the token kind on rsp_tuser: end, number (saturated at
// 2^31-1), variable, the twenty keywords and operators, or error for an unknown byte
// or a lone '<' or ':'. A byte causes zero, one or two tokens; rsp_tlast marks the
// last token of a byte. The front end takes a byte every cycle while its queue of
// QUEUE_DEPTH entries has room, so the input rate is one byte per cycle; the result
// port moves one token per cycle while rsp_tready is high, so a byte that closes a
// pending token and also yields a token of its own needs an output beat for each,
// and the queue absorbs such bursts; a token passes the queue and the output register.
// After the end token all state returns to reset and the next text starts at offset 0.
module keyword_token_lexer_top import klx_pkg::*; #(
   parameter int POSITION_BITS = 16,  // byte offset counter width, 8..32
   parameter int QUEUE_DEPTH   = 4    // token-pair entries between front and back
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tlast,   // text_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [30:0] number_value, [46:31] token_start,
                                    // [62:47] token_length, [63] 0
   output logic [4:0]  rsp_tuser,   // [4:0] token_kind
   output logic        rsp_tlast    // run_last
);

   queue_status_type q_status;
   logic             push, pop;
   token_pair_type   push_data, head;
   lex_token_type    out_token;

   // front: scans bytes, keeps the token state, classifies words
   klx_front #(
      .POSITION_BITS(POSITION_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_ch    (req_tdata),
      .in_end   (req_tlast),
      .q_status (q_status),
      .push     (push),
      .push_data(push_data)
   );

   // queue of per-byte token pairs
   klx_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   // back: splits pairs into single beats behind an output register
   klx_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .head     (head),
      .pop      (pop),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_token(out_token),
      .out_last (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, out_token.length, out_token.start, out_token.value};
   assign rsp_tuser = out_token.kind;

endmodule

FILE: rtl/klx_checker.sv
module klx_checker import klx_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic [4:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // a stalled source beat holds
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata) && $stable(req_tlast))
      else $error("req beat changed while stalled");

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp beat changed while stalled");

   // end token is empty and always closes its byte's run
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_END |-> rsp_tlast && rsp_tdata[62:47] == 16'd0)
      else $error("end token malformed");

   // only number tokens carry a value
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_NUM |-> rsp_tdata[30:0] == 31'h0)
      else $error("value on non-number token");

   // output register empties on reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp valid right after reset");

endmodule

bind keyword_token_lexer_top klx_checker u_klx_checker (.*);

FILE: tb/tb_keyword_token_lexer_top.sv
`timescale 1ns / 100ps

module tb_keyword_token_lexer_top;
   import klx_pkg::*;

   // Expected token, as the scoreboard holds it.
   typedef struct packed {
      logic [4:0]  kind;
      logic [30:0] value;
      logic [15:0] start;
      logic [15:0] length;
      logic        last;
   } exp_token_type;

   // One row of the directed table. When typed is set, tok is the token the
   // beat must produce (exactly one); otherwise the lexer model decides.
   typedef struct packed {
      logic [7:0]    ch;
      logic          last;
      logic          typed;
      exp_token_type tok;
   } dir_row_type;

   localparam int DIR_ROWS = 23;
   localparam int RANDOM_BEATS = 2000;
   localparam int DRAIN_LIMIT = 10000;

   localparam exp_token_type NO_TOKEN = '0;

   // Offsets in the comments are byte offsets within the current text.
   localparam dir_row_type DIRECTED [DIR_ROWS] = '{
      '{"+",   1'b0, 1'b1, '{KIND_PLUS, 31'd0, 16'd0, 16'd1, 1'b1}},   // op at offset 0
      '{8'hFF, 1'b0, 1'b1, '{KIND_ERR,  31'd0, 16'd1, 16'd1, 1'b1}},   // unknown high byte
      '{"<",   1'b0, 1'b0, NO_TOKEN},
      '{"=",   1'b0, 1'b1, '{KIND_LEQ,  31'd0, 16'd2, 16'd2, 1'b1}},
      '{":",   1'b0, 1'b0, NO_TOKEN},
      '{"d",   1'b0, 1'b1, '{KIND_ERR,  31'd0, 16'd4, 16'd1, 1'b1}},   // lone colon
      '{"o",   1'b0, 1'b0, NO_TOKEN},
      '{" ",   1'b0, 1'b1, '{KIND_DO,   31'd0, 16'd5, 16'd2, 1'b1}},
      '{"4",   1'b0, 1'b0, NO_TOKEN},                                   // 4294967296
      '{"2",   1'b0, 1'b0, NO_TOKEN},
      '{"9",   1'b0, 1'b0, NO_TOKEN},
      '{"4",   1'b0, 1'b0, NO_TOKEN},
      '{"9",   1'b0, 1'b0, NO_TOKEN},
      '{"6",   1'b0, 1'b0, NO_TOKEN},
      '{"7",   1'b0, 1'b0, NO_TOKEN},
      '{"2",   1'b0, 1'b0, NO_TOKEN},
      '{"9",   1'b0, 1'b0, NO_TOKEN},
      '{"6",   1'b0, 1'b0, NO_TOKEN},
      '{"x",   1'b0, 1'b1, '{KIND_NUM,  NUM_MAX, 16'd8, 16'd10, 1'b1}}, // saturated, digit-letter
      '{8'h80, 1'b1, 1'b0, NO_TOKEN},                                   // variable + end
      '{"<",   1'b0, 1'b0, NO_TOKEN},                                   // new text, offset 0
      '{8'h7F, 1'b1, 1'b0, NO_TOKEN},                                   // lone '<' + end
      '{8'h00, 1'b0, 1'b1, '{KIND_END,  31'd0, 16'd0, 16'd0, 1'b1}}    // zero byte closes
   };

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] ch
   logic        req_tlast;    // text_end
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;    // [30:0] value, [46:31] start, [62:47] length
   logic [4:0]  rsp_tuser;    // [4:0] kind
   logic        rsp_tlast;    // run_last

   keyword_token_lexer_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Lexer model state.
   scan_mode_type scan_state;
   logic [30:0]   num_acc;
   logic [39:0]   word_bytes;
   logic [15:0]   tok_len;
   logic [15:0]   tok_start;
   logic [15:0]   byte_pos;

   exp_token_type byte_tokens [$];     // tokens caused by the beat just accepted
   exp_token_type pending_tokens [$];  // tokens still owed by the block
   exp_token_type arrived_want;

   int   error_count = 0;
   int   beats_sent = 0;
   logic idle_on = 1'b1;

   string keyword_words [10] = '{"true", "false", "skip", "if", "then",
                                 "else", "fi", "while", "do", "done"};
   string operator_words [10] = '{"+", "-", "*", "/", "=", "!", "&", ";", "<=", ":="};

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // ---------------------------------------------------------------------
   // Character classes and keyword lookup
   // ---------------------------------------------------------------------
   function automatic logic is_dec(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_blank(logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic [4:0] op_kind(logic [7:0] c);
      logic [4:0] k;
      case (c)
         "+": k = KIND_PLUS;
         "-": k = KIND_MINUS;
         "*": k = KIND_STAR;
         "/": k = KIND_SLASH;
         "=": k = KIND_EQ;
         "!": k = KIND_NOT;
         "&": k = KIND_AND;
         ";": k = KIND_SEMI;
         default: k = KIND_ERR;
      endcase
      return k;
   endfunction

   // Word bytes sit right-aligned, so short words only need their low bytes.
   function automatic logic [4:0] keyword_of(logic [39:0] w, logic [15:0] n);
      logic [4:0] k;
      k = KIND_VAR;
      if (n == 16'd2) begin
         case (w[15:0])
            "if": k = KIND_IF;
            "fi": k = KIND_FI;
            "do": k = KIND_DO;
            default: k = KIND_VAR;
         endcase
      end else if (n == 16'd4) begin
         case (w[31:0])
            "true": k = KIND_TRUE;
            "skip": k = KIND_SKIP;
            "then": k = KIND_THEN;
            "else": k = KIND_ELSE;
            "done": k = KIND_DONE;
            default: k = KIND_VAR;
         endcase
      end else if (n == 16'd5) begin
         case (w)
            "false": k = KIND_FALSE;
            "while": k = KIND_WHILE;
            default: k = KIND_VAR;
         endcase
      end
      return k;
   endfunction

   // ---------------------------------------------------------------------
   // Lexer model: one accepted beat in, its tokens out in byte_tokens
   // ---------------------------------------------------------------------
   task automatic clear_lexer();
      scan_state = MODE_IDLE;
      num_acc    = '0;
      word_bytes = '0;
      tok_len    = '0;
      tok_start  = '0;
      byte_pos   = '0;
   endtask

   task automatic add_token(input logic [4:0] k, input logic [30:0] v,
                            input logic [15:0] s, input logic [15:0] n);
      exp_token_type t;
      t = '{k, v, s, n, 1'b0};
      byte_tokens.push_back(t);
   endtask

   task automatic lex_byte(input logic [7:0] c, input logic e);
      logic        at_end;
      logic        consumed;
      logic [35:0] grown;
      byte_tokens.delete();
      at_end   = e || c == 8'h00;
      consumed = 1'b0;
      case (scan_state)
         MODE_NUM: begin
            if (!at_end && is_dec(c)) begin
               grown = {5'b0, num_acc} * 10 + (c - 8'h30);
               num_acc = grown > NUM_MAX ? NUM_MAX : grown[30:0];
               if (tok_len != LEN_MAX) tok_len++;
               byte_pos++;
               consumed = 1'b1;
            end else begin
               add_token(KIND_NUM, num_acc, tok_start, tok_len);
               scan_state = MODE_IDLE;
            end
         end
         MODE_WORD: begin
            if (!at_end && (is_letter(c) || is_dec(c))) begin
               if (tok_len < 16'd5) word_bytes = {word_bytes[31:0], c};
               if (tok_len != LEN_MAX) tok_len++;
               byte_pos++;
               consumed = 1'b1;
            end else begin
               add_token(keyword_of(word_bytes, tok_len), '0, tok_start, tok_len);
               scan_state = MODE_IDLE;
            end
         end
         MODE_LT, MODE_COLON: begin
            if (!at_end && c == CHAR_EQ) begin
               add_token(scan_state == MODE_LT ? KIND_LEQ : KIND_ASSIGN, '0, tok_start, 16'd2);
               byte_pos++;
               consumed = 1'b1;
            end else begin
               add_token(KIND_ERR, '0, tok_start, 16'd1);
            end
            scan_state = MODE_IDLE;
         end
         default: scan_state = MODE_IDLE;
      endcase

      if (!consumed) begin
         if (at_end) begin
            add_token(KIND_END, '0, byte_pos, 16'd0);
            clear_lexer();
         end else begin
            tok_start = byte_pos;
            if (is_dec(c)) begin
               scan_state = MODE_NUM;
               num_acc    = 31'(c - 8'h30);
               tok_len    = 16'd1;
            end else if (is_letter(c)) begin
               scan_state = MODE_WORD;
               word_bytes = {32'b0, c};
               tok_len    = 16'd1;
            end else if (c == CHAR_LT) begin
               scan_state = MODE_LT;
            end else if (c == CHAR_COLON) begin
               scan_state = MODE_COLON;
            end else if (!is_blank(c)) begin
               add_token(op_kind(c), '0, byte_pos, 16'd1);
            end
            byte_pos++;
         end
      end

      // the last token of the beat carries tlast
      if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size() - 1].last = 1'b1;
   endtask

   // ---------------------------------------------------------------------
   // Source side
   // ---------------------------------------------------------------------
   // Drives one beat, holding it until accepted. valid is left high on return
   // so back-to-back beats need no second assignment in the same step.
   task automatic send_beat(input logic [7:0] c, input logic e,
                            input logic use_typed = 1'b0, input exp_token_type typed = '0);
      while (idle_on && $urandom_range(99) < 36) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= e;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      lex_byte(c, e);
      if (use_typed) pending_tokens.push_back(typed);
      else foreach (byte_tokens[i]) pending_tokens.push_back(byte_tokens[i]);
      beats_sent++;
   endtask

   // Hold off the source until the block has delivered everything owed.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_tokens.size() != 0);
   endtask

   function automatic logic [7:0] rand_letter();
      int r;
      r = $urandom_range(51);
      return r < 26 ? 8'("a" + r) : 8'("A" + r - 26);
   endfunction

   function automatic logic [7:0] rand_alnum();
      return $urandom_range(3) == 0 ? 8'(8'h30 + $urandom_range(9)) : rand_letter();
   endfunction

   function automatic logic [7:0] rand_blank();
      int r;
      r = $urandom_range(5);
      return r == 5 ? 8'h20 : 8'(9 + r);
   endfunction

   // Any byte the language has no use for, high bytes included.
   function automatic logic [7:0] rand_unknown();
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255));
      while (is_dec(c) || is_letter(c) || is_blank(c) || op_kind(c) != KIND_ERR ||
             c == CHAR_LT || c == CHAR_COLON);
      return c;
   endfunction

   task automatic send_string(input string s);
      for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
   endtask

   // One lexical piece: mostly well-formed, some noise.
   task automatic send_fragment();
      int r;
      int n;
      r = $urandom_range(99);
      if (r < 25) begin
         send_string(keyword_words[$urandom_range(9)]);
         // keyword run straight into more word chars -> variable
         if ($urandom_range(4) == 0) send_beat(rand_alnum(), 1'b0);
      end else if (r < 40) begin
         n = $urandom_range(3) == 0 ? $urandom_range(7, 12) : $urandom_range(1, 6);
         send_beat(rand_letter(), 1'b0);
         repeat (n - 1) send_beat(rand_alnum(), 1'b0);
      end else if (r < 55) begin
         // long runs push the value past 2^31-1
         n = $urandom_range(4) == 0 ? $urandom_range(9, 13) : $urandom_range(1, 4);
         repeat (n) send_beat(8'(8'h30 + $urandom_range(9)), 1'b0);
      end else if (r < 75) begin
         send_string(operator_words[$urandom_range(9)]);
      end else if (r < 83) begin
         send_beat($urandom_range(1) ? CHAR_LT : CHAR_COLON, 1'b0);
      end else if (r < 93) begin
         send_beat(rand_blank(), 1'b0);
      end else begin
         send_beat(rand_unknown(), 1'b0);
      end
   endtask

   // A whole text: fragments, sometimes glued together, closed by tlast
   // (with a junk byte) or by a zero byte.
   task automatic send_text();
      int frags;
      frags = $urandom_range(1, 30);
      repeat (frags) begin
         send_fragment();
         if ($urandom_range(99) < 60) send_beat(rand_blank(), 1'b0);
      end
      if ($urandom_range(1)) send_beat(8'($urandom_range(255)), 1'b1);
      else send_beat(8'h00, 1'b0);
   endtask

   // ---------------------------------------------------------------------
   // Sink side: random backpressure, and the scoreboard
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_tready <= !idle_on || $urandom_range(99) >= 36;
   end

   task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: token %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_tokens.size() == 0) begin
            $display("%0t: unexpected token, expected none, actual kind %0d start %0d",
                     $time, rsp_tuser, rsp_tdata[46:31]);
            error_count++;
         end else begin
            arrived_want = pending_tokens.pop_front();
            check_field("kind",   arrived_want.kind,   rsp_tuser);
            check_field("value",  arrived_want.value,  rsp_tdata[30:0]);
            check_field("start",  arrived_want.start,  rsp_tdata[46:31]);
            check_field("length", arrived_want.length, rsp_tdata[62:47]);
            check_field("last",   arrived_want.last,   rsp_tlast);
            check_field("pad",    0,                   rsp_tdata[63]);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      int   drain_wait;
      logic paused;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      rsp_tready = 1'b0;
      paused     = 1'b0;
      clear_lexer();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int i = 0; i < DIR_ROWS; i++) begin
         send_beat(DIRECTED[i].ch, DIRECTED[i].last, DIRECTED[i].typed, DIRECTED[i].tok);
      end
      drain();

      // random texts; one stretch runs with no idling on either side,
      // and once the source waits for the block to empty
      while (beats_sent < DIR_ROWS + RANDOM_BEATS) begin
         idle_on = !(beats_sent >= 700 && beats_sent < 1100);
         if (!paused && beats_sent >= 1400) begin
            drain();
            paused = 1'b1;
         end
         send_text();
      end
      idle_on = 1'b1;

      req_tvalid <= 1'b0;
      drain_wait = 0;
      while (pending_tokens.size() != 0 && drain_wait < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_wait++;
      end
      // let any stray token show up
      repeat (20) @(posedge clock);

      if (error_count == 0 && pending_tokens.size() == 0) begin
         $display("** keyword_token_lexer_top: PASSED **");
      end else begin
         if (pending_tokens.size() != 0)
            $display("%0t: %0d expected tokens never arrived", $time, pending_tokens.size());
         $display("** keyword_token_lexer_top: FAILED **");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #25_000_000;
      $display("%0t: timeout", $time);
      $display("** keyword_token_lexer_top: FAILED **");
      $finish;
   end

endmodule
